/* rtl/core/csfw_pkg.sv */
// shared types and codes for the counting semaphore with fifo wait list
`default_nettype none

package csfw_pkg;

    localparam int ID_W    = 8;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        OP_INIT    = 3'd0,
        OP_PEND    = 3'd1,
        OP_TPEND   = 3'd2,
        OP_TRY     = 3'd3,
        OP_POST    = 3'd4,
        OP_TIMEOUT = 3'd5,
        OP_READ    = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_ACQUIRED  = 3'd1,
        ST_QUEUED    = 3'd2,
        ST_REFUSED   = 3'd3,
        ST_FULL      = 3'd4,
        ST_REMOVED   = 3'd5,
        ST_NOT_FOUND = 3'd6,
        ST_SATURATED = 3'd7
    } status_t;

    // broadcast command from the sequencer to every cell of the wait list
    typedef struct packed {
        logic clear;
        logic append;
        logic shift_all;
        logic use_mask;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/csfw_cell.sv */
// one wait list cell: holds a thread id and its valid bit
`default_nettype none

module csfw_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire csfw_pkg::cell_cmd_t         cmd,
    input  wire logic [csfw_pkg::ID_W-1:0]   tid,
    input  wire logic                        prev_valid,
    input  wire logic [csfw_pkg::ID_W-1:0]   next_id,
    input  wire logic                        next_valid,
    input  wire logic                        mask_bit,
    output logic [csfw_pkg::ID_W-1:0]        id,
    output logic                             valid,
    output logic                             hit
);

    logic [csfw_pkg::ID_W-1:0] id_reg;
    logic [csfw_pkg::ID_W-1:0] id_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      shift;
    logic                      load;

    // shift takes the neighbor's word, closing the gap toward the head
    assign shift = cmd.shift_all | (cmd.use_mask & mask_bit);
    // first free slot takes the appended word
    assign load  = cmd.append & ~valid_reg & prev_valid;

    always_comb
    begin
        id_next    = id_reg;
        valid_next = valid_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (shift)
        begin
            id_next    = next_id;
            valid_next = next_valid;
        end
        else if (load)
        begin
            id_next    = tid;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id    = id_reg;
    assign valid = valid_reg;
    assign hit   = valid_reg & (id_reg == tid);

endmodule

`default_nettype wire

/* rtl/core/counting_semaphore_fifo_waiters.sv */
// top level of the counting semaphore with a fifo list of waiting threads
`default_nettype none

// Counting semaphore with an ordered wait list held in a row of cells.
// An operation is taken when start is high and busy is low; its single
// result word appears on the result ports for exactly one cycle with done
// high, and must be captured then, since the receiver cannot stall it.
// Each operation runs a compare step that checks every cell against
// the thread id, a doubling prefix sweep that marks all cells at or
// behind the oldest match, and an execute step that updates the cells
// and the count. Busy stays high from the compare step until the execute
// step is over, so only one operation is in flight at a time.
// The sweep runs for every opcode. The initial count register
// is written through its own valid/ready channel, which is always ready;
// write it only while the block is idle. Init empties the wait list at
// once, with no clearing pass.
module counting_semaphore_fifo_waiters #(
    parameter int WAIT_DEPTH = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // command side
    input  wire logic         start,
    output logic              busy,
    input  wire logic [2:0]   opcode,
    input  wire logic [7:0]   thread_id,
    input  wire logic [15:0]  timeout_ms,
    input  wire logic         from_irq,
    // result side, one word per command
    output logic              done,
    output logic [2:0]        status,
    output logic [15:0]       count_value,
    output logic              woken_valid,
    output logic [7:0]        woken_thread,
    output logic              woken_from_irq,
    // initial count register write
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);

    localparam int STEPS  = $clog2(WAIT_DEPTH);
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    // one-hot sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_SCAN = 4'b0100,
        S_EXEC = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [csfw_pkg::COUNT_W-1:0] init_count_reg;
    logic [csfw_pkg::COUNT_W-1:0] count_reg;
    logic [csfw_pkg::COUNT_W-1:0] count_next;

    // latched command word
    csfw_pkg::op_t                op_reg;
    logic [csfw_pkg::ID_W-1:0]    tid_reg;
    logic                         tmo_nz_reg;
    logic                         irq_reg;

    logic [WAIT_DEPTH-1:0]        mask_reg;
    logic [STEP_W-1:0]            step_reg;

    // registered result word
    logic                         done_reg;
    csfw_pkg::status_t            status_reg;
    csfw_pkg::status_t            status_next;
    logic [csfw_pkg::COUNT_W-1:0] count_out_reg;
    logic                         woken_reg;
    logic                         woken_next;
    logic [csfw_pkg::ID_W-1:0]    woken_id_reg;
    logic [csfw_pkg::ID_W-1:0]    woken_id_next;
    logic                         woken_irq_reg;

    csfw_pkg::cell_cmd_t          cmd;
    csfw_pkg::cell_cmd_t          exec_cmd;

    // cell chain; index WAIT_DEPTH is the empty slot past the tail
    logic [csfw_pkg::ID_W-1:0]    id_w [0:WAIT_DEPTH];
    logic [WAIT_DEPTH:0]          valid_w;
    logic [WAIT_DEPTH-1:0]        hit_w;

    logic                         accept;
    logic                         may_wait;
    logic                         list_full;

    assign accept    = start & (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign id_w[WAIT_DEPTH]    = '0;
    assign valid_w[WAIT_DEPTH] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < WAIT_DEPTH; gi++)
        begin : g_cell
            logic prev_v;
            if (gi == 0)
            begin : g_head
                assign prev_v = 1'b1;
            end
            else
            begin : g_body
                assign prev_v = valid_w[gi-1];
            end

            csfw_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .tid        (tid_reg),
                .prev_valid (prev_v),
                .next_id    (id_w[gi+1]),
                .next_valid (valid_w[gi+1]),
                .mask_bit   (mask_reg[gi]),
                .id         (id_w[gi]),
                .valid      (valid_w[gi]),
                .hit        (hit_w[gi])
            );
        end
    endgenerate

    // list is full when the tail cell is occupied
    assign list_full = valid_w[WAIT_DEPTH-1];
    assign may_wait  = (op_reg == csfw_pkg::OP_PEND)
                     | ((op_reg == csfw_pkg::OP_TPEND) & tmo_nz_reg);

    // operation decode, used only in the execute cycle
    always_comb
    begin
        exec_cmd      = '0;
        count_next    = count_reg;
        status_next   = csfw_pkg::ST_DONE;
        woken_next    = 1'b0;
        woken_id_next = '0;
        case (op_reg)
            csfw_pkg::OP_INIT:
            begin
                count_next     = init_count_reg;
                exec_cmd.clear = 1'b1;
            end
            csfw_pkg::OP_PEND, csfw_pkg::OP_TPEND, csfw_pkg::OP_TRY:
            begin
                if (count_reg != '0)
                begin
                    count_next  = count_reg - 1'b1;
                    status_next = csfw_pkg::ST_ACQUIRED;
                end
                else if (!may_wait)
                begin
                    status_next = csfw_pkg::ST_REFUSED;
                end
                else if (list_full)
                begin
                    status_next = csfw_pkg::ST_FULL;
                end
                else
                begin
                    exec_cmd.append = 1'b1;
                    status_next     = csfw_pkg::ST_QUEUED;
                end
            end
            csfw_pkg::OP_POST:
            begin
                if (valid_w[0])
                begin
                    // hand the unit straight to the oldest waiter
                    woken_next         = 1'b1;
                    woken_id_next      = id_w[0];
                    exec_cmd.shift_all = 1'b1;
                end
                else if (count_reg == csfw_pkg::COUNT_MAX)
                begin
                    status_next = csfw_pkg::ST_SATURATED;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            csfw_pkg::OP_TIMEOUT:
            begin
                if (|mask_reg)
                begin
                    exec_cmd.use_mask = 1'b1;
                    status_next       = csfw_pkg::ST_REMOVED;
                end
                else
                begin
                    status_next = csfw_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = csfw_pkg::ST_DONE;
            end
        endcase
    end

    assign cmd = (state_reg == S_EXEC) ? exec_cmd : '0;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = (STEPS > 0) ? S_SCAN : S_EXEC;
            end
            S_SCAN:
            begin
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            init_count_reg <= '0;
            done_reg       <= 1'b0;
            step_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
            if (cfg_valid && cfg_ready)
            begin
                init_count_reg <= cfg_data;
            end
            if (state_reg == S_EXEC)
            begin
                count_reg <= count_next;
            end
            if (state_reg == S_CMP)
            begin
                step_reg <= '0;
            end
            else if (state_reg == S_SCAN)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= csfw_pkg::op_t'(opcode);
            tid_reg    <= thread_id;
            tmo_nz_reg <= (timeout_ms != '0);
            irq_reg    <= from_irq;
        end
        if (state_reg == S_CMP)
        begin
            mask_reg <= hit_w;
        end
        else if (state_reg == S_SCAN)
        begin
            // doubling prefix or: every cell at or behind the oldest match
            mask_reg <= mask_reg | (mask_reg << (1 << step_reg));
        end
        if (state_reg == S_EXEC)
        begin
            status_reg    <= status_next;
            count_out_reg <= count_next;
            woken_reg     <= woken_next;
            woken_id_reg  <= woken_id_next;
            woken_irq_reg <= woken_next & irq_reg;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign count_value    = count_out_reg;
    assign woken_valid    = woken_reg;
    assign woken_thread   = woken_id_reg;
    assign woken_from_irq = woken_irq_reg;

endmodule

`default_nettype wire

/* tb/sv/csfw_checker.sv */
// result checker for the counting semaphore: predicts every result word and compares it
module csfw_checker #(
    parameter int WAIT_DEPTH = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic         busy,
    input  wire logic [2:0]   opcode,
    input  wire logic [7:0]   thread_id,
    input  wire logic [15:0]  timeout_ms,
    input  wire logic         from_irq,
    input  wire logic         done,
    input  wire logic [2:0]   status,
    input  wire logic [15:0]  count_value,
    input  wire logic         woken_valid,
    input  wire logic [7:0]   woken_thread,
    input  wire logic         woken_from_irq,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [15:0]  cfg_data,
    output int                fail_count,
    output int                words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        csfw_pkg::status_t                st;
        logic [csfw_pkg::COUNT_W-1:0]     cnt;
        logic                             wv;
        logic [csfw_pkg::ID_W-1:0]        wt;
        logic                             wi;
    } sem_word_t;

    // mirror of the block state
    logic [csfw_pkg::COUNT_W-1:0] init_count;
    logic [csfw_pkg::COUNT_W-1:0] units;
    logic [csfw_pkg::ID_W-1:0]    waiters[$];
    sem_word_t                    due_words[$];
    int                           mismatches;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40)
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // take a unit, or queue the caller when allowed and there is room
    function automatic csfw_pkg::status_t take_unit(input logic [csfw_pkg::ID_W-1:0] tid,
                                                    input logic may_wait);
        if (units != '0)
        begin
            units--;
            return csfw_pkg::ST_ACQUIRED;
        end
        if (!may_wait)
            return csfw_pkg::ST_REFUSED;
        if (waiters.size() >= WAIT_DEPTH)
            return csfw_pkg::ST_FULL;
        waiters.push_back(tid);
        return csfw_pkg::ST_QUEUED;
    endfunction

    task automatic apply_op(input logic [2:0] op, input logic [csfw_pkg::ID_W-1:0] tid,
                            input logic [15:0] tmo, input logic irq, output sem_word_t w);
        int hit;
        w = '0;
        w.st = csfw_pkg::ST_DONE;
        case (op)
            csfw_pkg::OP_INIT:
            begin
                units = init_count;
                waiters.delete();
            end
            csfw_pkg::OP_PEND:  w.st = take_unit(tid, 1'b1);
            csfw_pkg::OP_TPEND: w.st = take_unit(tid, tmo != '0);
            csfw_pkg::OP_TRY:   w.st = take_unit(tid, 1'b0);
            csfw_pkg::OP_POST:
            begin
                if (waiters.size() != 0)
                begin
                    w.wv = 1'b1;
                    w.wt = waiters.pop_front();
                    w.wi = irq;
                end
                else if (units == csfw_pkg::COUNT_MAX)
                    w.st = csfw_pkg::ST_SATURATED;
                else
                    units++;
            end
            csfw_pkg::OP_TIMEOUT:
            begin
                hit = -1;
                for (int i = 0; i < waiters.size(); i++)
                    if (hit < 0 && waiters[i] == tid)
                        hit = i;
                if (hit >= 0)
                begin
                    waiters.delete(hit);
                    w.st = csfw_pkg::ST_REMOVED;
                end
                else
                    w.st = csfw_pkg::ST_NOT_FOUND;
            end
            default: ;
        endcase
        w.cnt = units;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sem_word_t w;
        if (!rst_n)
        begin
            init_count = '0;
            units = '0;
            waiters.delete();
            due_words.delete();
            mismatches = 0;
            words_due <= 0;
        end
        else
        begin
            if (done)
            begin
                if (due_words.size() == 0)
                    report_mismatch("unexpected word", int'(status), 0);
                else
                begin
                    w = due_words.pop_front();
                    if (status !== w.st)
                        report_mismatch("status", int'(status), int'(w.st));
                    if (count_value !== w.cnt)
                        report_mismatch("count_value", int'(count_value), int'(w.cnt));
                    if (woken_valid !== w.wv)
                        report_mismatch("woken_valid", int'(woken_valid), int'(w.wv));
                    if (woken_thread !== w.wt)
                        report_mismatch("woken_thread", int'(woken_thread), int'(w.wt));
                    if (woken_from_irq !== w.wi)
                        report_mismatch("woken_from_irq", int'(woken_from_irq), int'(w.wi));
                end
            end
            if (cfg_valid && cfg_ready)
                init_count = cfg_data;
            if (start && !busy)
            begin
                apply_op(opcode, thread_id, timeout_ms, from_irq, w);
                due_words.push_back(w);
            end
            words_due <= due_words.size();
        end
    end

endmodule

/* tb/sv/tb_counting_semaphore_fifo_waiters.sv */
// testbench top for the counting semaphore: drives commands and config, gives the verdict
module tb_counting_semaphore_fifo_waiters;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WAIT_DEPTH = 16;
    // opcode 7 is not defined and must behave like a read
    localparam logic [2:0] OP_SPARE = 3'd7;
    // watchdog limit, set generously above what a correct run needs
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 175;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic [2:0]   opcode = csfw_pkg::OP_READ;
    logic [7:0]   thread_id = '0;
    logic [15:0]  timeout_ms = '0;
    logic         from_irq = 1'b0;
    logic         cfg_valid = 1'b0;
    logic [15:0]  cfg_data = '0;
    logic         busy;
    logic         done;
    logic [2:0]   status;
    logic [15:0]  count_value;
    logic         woken_valid;
    logic [7:0]   woken_thread;
    logic         woken_from_irq;
    logic         cfg_ready;
    int           fail_count;
    int           words_due;
    int           cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    counting_semaphore_fifo_waiters #(
        .WAIT_DEPTH     (WAIT_DEPTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .thread_id      (thread_id),
        .timeout_ms     (timeout_ms),
        .from_irq       (from_irq),
        .done           (done),
        .status         (status),
        .count_value    (count_value),
        .woken_valid    (woken_valid),
        .woken_thread   (woken_thread),
        .woken_from_irq (woken_from_irq),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    csfw_checker #(
        .WAIT_DEPTH     (WAIT_DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .thread_id      (thread_id),
        .timeout_ms     (timeout_ms),
        .from_irq       (from_irq),
        .done           (done),
        .status         (status),
        .count_value    (count_value),
        .woken_valid    (woken_valid),
        .woken_thread   (woken_thread),
        .woken_from_irq (woken_from_irq),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .words_due      (words_due)
    );

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // present one command and hold it until the block takes it;
    // returns at the accepting edge with start still high
    task automatic issue(input logic [2:0] op, input logic [7:0] tid,
                         input logic [15:0] tmo, input logic irq);
        start <= 1'b1;
        opcode <= op;
        thread_id <= tid;
        timeout_ms <= tmo;
        from_irq <= irq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // random idle cycles between commands, pct is the per-cycle idle chance
    task automatic sender_gap(input int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < pct);
        end
    endtask

    // stop sending and wait until every predicted word has come back;
    // words_due is registered, so the first look comes in the cycle after the accept
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (words_due != 0);
    endtask

    // register write, only called while the block is idle
    task automatic write_init_count(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // one random command; ids come mostly from a small pool so that
    // timeouts hit and duplicate waiters show up, the rest span all 8 bits
    task automatic random_op(input int pct);
        int          roll;
        logic [2:0]  op;
        logic [7:0]  tid;
        logic [15:0] tmo;
        roll = $urandom_range(99);
        if (roll < 30)
            op = csfw_pkg::OP_PEND;
        else if (roll < 45)
            op = csfw_pkg::OP_TPEND;
        else if (roll < 53)
            op = csfw_pkg::OP_TRY;
        else if (roll < 78)
            op = csfw_pkg::OP_POST;
        else if (roll < 92)
            op = csfw_pkg::OP_TIMEOUT;
        else if (roll < 96)
            op = csfw_pkg::OP_READ;
        else if (roll < 98)
            op = csfw_pkg::OP_INIT;
        else
            op = OP_SPARE;
        tid = ($urandom_range(99) < 85) ? 8'($urandom_range(15)) : 8'($urandom);
        // zero timeout often, so timed pend refusals are common
        tmo = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom);
        sender_gap(pct);
        issue(op, tid, tmo, 1'($urandom_range(1)));
    endtask

    initial
    begin
        logic [15:0] phase_count[6];
        int          idle_pct;

        phase_count = '{16'd3, 16'd0, 16'hFFFF, 16'd1, 16'($urandom), 16'd0};

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        write_init_count(16'd2);
        issue(csfw_pkg::OP_READ, 8'h00, 16'h0000, 1'b0);
        // empty list, count 0: post raises the count, irq flag must not leak out
        issue(csfw_pkg::OP_POST, 8'h00, 16'h0000, 1'b1);
        issue(csfw_pkg::OP_INIT, 8'h00, 16'h0000, 1'b0);
        issue(csfw_pkg::OP_PEND, 8'h00, 16'h0000, 1'b0);
        issue(csfw_pkg::OP_TRY, 8'hFF, 16'hFFFF, 1'b0);
        // count is now zero
        issue(csfw_pkg::OP_TRY, 8'h01, 16'h0000, 1'b0);
        issue(csfw_pkg::OP_TPEND, 8'h11, 16'h0000, 1'b0);
        issue(csfw_pkg::OP_TPEND, 8'h22, 16'hFFFF, 1'b0);
        issue(csfw_pkg::OP_PEND, 8'h33, 16'h0000, 1'b0);
        // same thread waiting twice
        issue(csfw_pkg::OP_PEND, 8'h22, 16'h0000, 1'b0);
        // fill the wait list to the top, then overflow with both pend kinds
        for (int i = 0; i < WAIT_DEPTH - 3; i++)
            issue(csfw_pkg::OP_PEND, 8'(8'h40 + i), 16'h0000, 1'b0);
        issue(csfw_pkg::OP_PEND, 8'h55, 16'h0000, 1'b0);
        issue(csfw_pkg::OP_TPEND, 8'h66, 16'h0001, 1'b0);
        // oldest of the duplicates goes, then a miss
        issue(csfw_pkg::OP_TIMEOUT, 8'h22, 16'h0000, 1'b0);
        issue(csfw_pkg::OP_TIMEOUT, 8'h99, 16'h0000, 1'b0);
        // wakes in arrival order, with and without irq context
        issue(csfw_pkg::OP_POST, 8'h00, 16'h0000, 1'b1);
        issue(csfw_pkg::OP_POST, 8'h00, 16'h0000, 1'b0);
        issue(OP_SPARE, 8'hA5, 16'h5A5A, 1'b1);

        // top of the count range: saturation and stepping back into it
        drain();
        write_init_count(16'hFFFF);
        issue(csfw_pkg::OP_INIT, 8'h00, 16'h0000, 1'b0);
        issue(csfw_pkg::OP_POST, 8'h00, 16'h0000, 1'b0);
        issue(csfw_pkg::OP_PEND, 8'h07, 16'h0000, 1'b0);
        issue(csfw_pkg::OP_POST, 8'h00, 16'h0000, 1'b1);

        // ---- random part ----
        // each phase starts idle with a fresh initial count and an init;
        // sender idles 15% in the first two, 51% in the next two, never after
        for (int p = 0; p < 6; p++)
        begin
            idle_pct = (p < 2) ? 15 : (p < 4) ? 51 : 0;
            drain();
            write_init_count(phase_count[p]);
            issue(csfw_pkg::OP_INIT, 8'($urandom), 16'($urandom), 1'($urandom_range(1)));
            for (int n = 1; n < PHASE_ITEMS; n++)
                random_op(idle_pct);
        end

        // wait out the last words, then keep the clock running to catch anything stray
        drain();
        repeat (20)
            @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/csfw_pkg.sv
rtl/core/csfw_cell.sv
rtl/core/counting_semaphore_fifo_waiters.sv
tb/sv/csfw_checker.sv
tb/sv/tb_counting_semaphore_fifo_waiters.sv
